>>> src/pfdr_pkg.sv
// ----------------------------------------------------------------------------
// pfdr_pkg: shared types and constants of the packet FIFO dedup/count unit
// Sizes of the cell row, field widths, request codes and the structs that
// travel between the top level and its cells.
// ----------------------------------------------------------------------------
package pfdr_pkg;

  localparam int DEPTH   = 64;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int CFG_W   = 7;
  localparam int LIM_W   = (CFG_W > OCC_W) ? CFG_W : OCC_W;
  localparam int GROUP   = 8;
  localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;
  localparam int GRP_W   = $clog2(GROUP + 1);

  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(64);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FWD   = 2'd1,
    OP_COUNT = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
  } query_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

>>> src/packet_fifo_dedup_range_count_unit.sv
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count_unit: bounded packet FIFO with duplicate check
// Stores packets in arrival order in a row of cells, refuses duplicates,
// forwards the oldest packet and counts packets by destination and time.
// ----------------------------------------------------------------------------
// Every request passes through these steps from acceptance to its result: it
// is accepted, every cell compares its packet with the request, the match flags
// are counted in groups of eight, and the row is updated and the result is
// loaded into the output register, a step that waits while that register holds
// a result out_ready has not taken. A new request is accepted only once the
// last one is through; the result register lets a finished result wait for
// out_ready while the next request is already taken. The packets live in a row
// of cells with the oldest packet always in cell 0: forwarding or evicting
// shifts the whole row one cell toward the head, and an add writes the first
// free cell. The entry limit is written through the cfg channel while the unit
// is idle; the user must keep to this, as the unit does not enforce it. Zero
// acts as one and values above the row length act as the row length.
module packet_fifo_dedup_range_count_unit import pfdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // Request channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   src_id,
  input  logic [ID_W-1:0]   dst_id,
  input  logic [TIME_W-1:0] stamp,
  input  logic [TIME_W-1:0] range_start,
  input  logic [TIME_W-1:0] range_end,
  // Result channel.
  output logic              out_valid,
  input  logic              out_ready,
  output logic              accepted,
  output logic              packet_valid,
  output logic [ID_W-1:0]   out_src,
  output logic [ID_W-1:0]   out_dst,
  output logic [TIME_W-1:0] out_stamp,
  output logic [OCC_W-1:0]  match_count,
  // Configuration channel: entry limit.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  // One-hot request sequencer.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SUM  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0] entry_limit;
  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;

  // The accepted request is held here for the whole sequence.
  op_t    op_q;
  query_t query;

  entry_t           ents      [DEPTH];
  cell_ctl_t        ctls      [DEPTH];
  logic [DEPTH-1:0] dup_hits;
  logic [DEPTH-1:0] cnt_hits;
  logic [OCC_W-1:0] total;
  entry_t           new_entry;

  logic             fire;
  logic             dup;
  logic [LIM_W-1:0] lim_eff;
  logic             add_commit;
  logic             evict;
  logic             fwd_commit;
  logic             shift_row;
  logic [OCC_W-1:0] load_pos;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q        <= op_t'(op);
      query.src   <= src_id;
      query.dst   <= dst_id;
      query.stamp <= stamp;
      query.lo    <= range_start;
      query.hi    <= range_end;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The update commits once the result register is free or being emptied.
  assign fire = (state == S_UPD) && (!out_valid || out_ready);
  assign dup  = |dup_hits;

  always_comb begin
    lim_eff = LIM_W'(entry_limit);
    if (lim_eff == '0) begin
      lim_eff = LIM_W'(1);
    end
    if (lim_eff > LIM_W'(DEPTH)) begin
      lim_eff = LIM_W'(DEPTH);
    end
  end

  // The duplicate check looks at the row before any eviction, so adding a
  // copy of the oldest packet is refused even when the store is full.
  assign add_commit = (op_q == OP_ADD) && !dup;
  assign evict      = add_commit && (LIM_W'(occupancy) >= lim_eff);
  assign fwd_commit = (op_q == OP_FWD) && (occupancy != '0);
  assign shift_row  = fire && (evict || fwd_commit);
  assign load_pos   = evict ? (occupancy - OCC_W'(1)) : occupancy;
  assign new_entry  = '{valid: 1'b1, src: query.src, dst: query.dst, stamp: query.stamp};

  always_comb begin
    occupancy_next = occupancy;
    if (fire) begin
      if (add_commit && !evict) begin
        occupancy_next = occupancy + OCC_W'(1);
      end else if (fwd_commit) begin
        occupancy_next = occupancy - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  // The row of cells; the last cell takes an empty packet when shifting.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t right;

    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = ents[i + 1];
    end

    assign ctls[i].shift = shift_row;
    assign ctls[i].load  = fire && add_commit &&
                           (load_pos[IDX_W-1:0] == IDX_W'(i));

    pfdr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctls[i]),
      .load_data (new_entry),
      .right     (right),
      .query     (query),
      .ent       (ents[i]),
      .dup_hit   (dup_hits[i]),
      .cnt_hit   (cnt_hits[i])
    );
  end

  pfdr_count u_count (
    .clk   (clk),
    .hits  (cnt_hits),
    .total (total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Fields that do not belong to the request's kind read as zero.
  always_ff @(posedge clk) begin
    if (fire) begin
      accepted     <= add_commit;
      packet_valid <= fwd_commit;
      out_src      <= fwd_commit ? ents[0].src : '0;
      out_dst      <= fwd_commit ? ents[0].dst : '0;
      out_stamp    <= fwd_commit ? ents[0].stamp : '0;
      match_count  <= (op_q == OP_COUNT) ? total : '0;
    end
  end

endmodule

>>> src/pfdr_cell.sv
// ----------------------------------------------------------------------------
// pfdr_cell: one storage cell of the packet row
// Holds one packet, compares it against the current request and either
// takes its right neighbor's packet or a freshly added one.
// ----------------------------------------------------------------------------
module pfdr_cell import pfdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    load_data,
  input  entry_t    right,
  input  query_t    query,
  output entry_t    ent,
  output logic      dup_hit,
  output logic      cnt_hit
);

  logic              valid;
  logic [ID_W-1:0]   src;
  logic [ID_W-1:0]   dst;
  logic [TIME_W-1:0] stamp;

  assign ent = '{valid: valid, src: src, dst: dst, stamp: stamp};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= load_data.valid;
    end else if (ctl.shift) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      src   <= load_data.src;
      dst   <= load_data.dst;
      stamp <= load_data.stamp;
    end else if (ctl.shift) begin
      src   <= right.src;
      dst   <= right.dst;
      stamp <= right.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dup_hit <= 1'b0;
      cnt_hit <= 1'b0;
    end else begin
      dup_hit <= valid && (src == query.src) && (dst == query.dst) &&
                 (stamp == query.stamp);
      cnt_hit <= valid && (dst == query.dst) && (stamp >= query.lo) &&
                 (stamp <= query.hi);
    end
  end

endmodule

>>> src/pfdr_count.sv
// ----------------------------------------------------------------------------
// pfdr_count: population count of the cells' match flags
// Counts the flags in small groups into registers; the group counts are
// then added into the total.
// ----------------------------------------------------------------------------
module pfdr_count import pfdr_pkg::*; (
  input  logic             clk,
  input  logic [DEPTH-1:0] hits,
  output logic [OCC_W-1:0] total
);

  logic [GRP_W-1:0] grp_cnt [NGROUP];
  logic [GRP_W-1:0] grp_cnt_next [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_cnt_next[g] = '0;
      for (int b = 0; b < GROUP; b++) begin
        if (g * GROUP + b < DEPTH) begin
          grp_cnt_next[g] = grp_cnt_next[g] + GRP_W'(hits[g * GROUP + b]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_cnt[g] <= grp_cnt_next[g];
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGROUP; g++) begin
      total = total + OCC_W'(grp_cnt[g]);
    end
  end

endmodule
